>>> hdl/tmslf_pkg.sv
package tmslf_pkg;

  localparam int CHANNELS  = 8;
  localparam int CH_W      = 3;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_W  = 12;
  localparam int N_SAMPLES = 5;

  // sum of the middle three samples, at most 3 * 4095
  localparam int SUM_W     = 14;
  // raw sum of all five samples
  localparam int TOTAL_W   = 15;

  // floor(sum / 30) == (sum * RECIP) >> RECIP_SHIFT for every sum below 2**14
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP = 15'd17477;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int Q_W         = 9;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
  localparam logic [SAMPLE_W-1:0] RISE_RESET = 12'd50;
  localparam logic [SAMPLE_W-1:0] FALL_RESET = 12'd60;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_LIMIT = 2'd0,
    CFG_FALL_LIMIT = 2'd1
  } cfg_reg_e;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CH_W-1:0]     chan_t;

  typedef struct packed {
    sample_t rise;
    sample_t fall;
  } slew_cfg_t;

endpackage

>>> hdl/tmslf_if.sv
interface tmslf_in_if;
  import tmslf_pkg::*;

  logic    valid;
  logic    ready;
  chan_t   channel;
  sample_t sample_a;
  sample_t sample_b;
  sample_t sample_c;
  sample_t sample_d;
  sample_t sample_e;

  modport source (
    output valid, channel, sample_a, sample_b, sample_c, sample_d, sample_e,
    input  ready
  );
  modport sink (
    input  valid, channel, sample_a, sample_b, sample_c, sample_d, sample_e,
    output ready
  );
endinterface

interface tmslf_out_if;
  import tmslf_pkg::*;

  logic    valid;
  logic    ready;
  chan_t   out_channel;
  sample_t quantized_mean;
  sample_t filtered_value;

  modport source (
    output valid, out_channel, quantized_mean, filtered_value,
    input  ready
  );
  modport sink (
    input  valid, out_channel, quantized_mean, filtered_value,
    output ready
  );
endinterface

interface tmslf_cfg_if;
  import tmslf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  sample_t              data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

>>> hdl/tmslf_trim.sv
module tmslf_trim (
  input  tmslf_pkg::sample_t                  smp_i [tmslf_pkg::N_SAMPLES],
  output logic [tmslf_pkg::SUM_W-1:0]         mid_sum_o
);
  import tmslf_pkg::*;

  sample_t            lo;
  sample_t            hi;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] trimmed;

  // running min, max and sum over the five samples
  always_comb begin
    lo    = smp_i[0];
    hi    = smp_i[0];
    total = '0;
    for (int i = 0; i < N_SAMPLES; i++) begin
      total = total + TOTAL_W'(smp_i[i]);
      if (smp_i[i] < lo) begin
        lo = smp_i[i];
      end
      if (smp_i[i] > hi) begin
        hi = smp_i[i];
      end
    end
    trimmed = total - TOTAL_W'(lo) - TOTAL_W'(hi);
  end

  assign mid_sum_o = trimmed[SUM_W-1:0];

endmodule

>>> hdl/tmslf_slew.sv
module tmslf_slew (
  input  tmslf_pkg::slew_cfg_t cfg_i,
  input  tmslf_pkg::sample_t   prev_i,
  input  tmslf_pkg::sample_t   target_i,
  output tmslf_pkg::sample_t   next_o
);
  import tmslf_pkg::*;

  sample_t             up_diff;
  sample_t             dn_diff;
  logic [SAMPLE_W:0]   up_val;

  assign up_diff = target_i - prev_i;
  assign dn_diff = prev_i - target_i;
  assign up_val  = {1'b0, prev_i} + {1'b0, cfg_i.rise};

  always_comb begin
    next_o = target_i;
    if (target_i >= prev_i) begin
      if (up_diff > cfg_i.rise) begin
        // saturate at full scale
        next_o = (up_val > {1'b0, FULL_SCALE}) ? FULL_SCALE : up_val[SAMPLE_W-1:0];
      end
    end else if (dn_diff > cfg_i.fall) begin
      next_o = prev_i - cfg_i.fall;
    end
  end

endmodule

>>> hdl/trimmed_mean_slew_limit_filter_top.sv
// Trimmed-mean filter with per-channel slew limit. Each input beat carries a
// channel number and five 12-bit samples; the smallest and largest sample are
// dropped, the middle three averaged (rounded down) and floored to a multiple
// of ten. The change from the channel's stored value is then capped at
// rise_limit upwards and fall_limit downwards, the capped value is stored and
// returned with the quantized mean. One beat is accepted per clock unless
// out_o stalls; a beat passes through the input register, trim-sum register,
// reciprocal multiply register and result register before showing on out_o.
// The per-channel store is read and written in the last stage, so beats on
// the same channel may follow each other back to back.
// Configuration is always ready and should be written while no beat is in
// flight; index 0 is rise_limit, index 1 fall_limit, other indexes are ignored.
module trimmed_mean_slew_limit_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmslf_cfg_if.sink   cfg_i,
  tmslf_in_if.sink    in_i,
  tmslf_out_if.source out_o
);
  import tmslf_pkg::*;

  // configuration registers
  slew_cfg_t cfg_q;

  // per-channel filtered value
  sample_t   last_q [CHANNELS];

  // stage 1: raw input beat
  logic      s1_vld_q;
  chan_t     s1_ch_q;
  sample_t   s1_smp_q [N_SAMPLES];

  // stage 2: middle three sum
  logic             s2_vld_q;
  chan_t            s2_ch_q;
  logic [SUM_W-1:0] s2_sum_q;

  // stage 3: sum divided by thirty
  logic           s3_vld_q;
  chan_t          s3_ch_q;
  logic [Q_W-1:0] s3_q_q;

  // result register
  logic    out_vld_q;
  chan_t   out_ch_q;
  sample_t out_mean_q;
  sample_t out_filt_q;

  logic              out_rdy;
  logic              s3_free;
  logic              s2_free;
  logic              s1_free;
  logic              s3_adv;
  logic              in_acc;
  logic [SUM_W-1:0]  mid_sum;
  logic [PROD_W-1:0] prod;
  sample_t           quant;
  logic              ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  sample_t           prev;
  sample_t           next_val;

  // ------------------------------------------------------------------
  // flow control: a stage takes a new beat when empty or moving on
  // ------------------------------------------------------------------
  assign out_rdy = !out_vld_q || out_o.ready;
  assign s3_free = !s3_vld_q || out_rdy;
  assign s2_free = !s2_vld_q || s3_free;
  assign s1_free = !s1_vld_q || s2_free;
  assign s3_adv  = s3_vld_q && out_rdy;

  assign in_i.ready = s1_free;
  assign in_acc     = in_i.valid && s1_free;

  assign cfg_i.ready = 1'b1;

  // ------------------------------------------------------------------
  // configuration writes
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise <= RISE_RESET;
      cfg_q.fall <= FALL_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_RISE_LIMIT: cfg_q.rise <= cfg_i.data;
        CFG_FALL_LIMIT: cfg_q.fall <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // stage 1: input register
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_free) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ch_q     <= in_i.channel;
      s1_smp_q[0] <= in_i.sample_a;
      s1_smp_q[1] <= in_i.sample_b;
      s1_smp_q[2] <= in_i.sample_c;
      s1_smp_q[3] <= in_i.sample_d;
      s1_smp_q[4] <= in_i.sample_e;
    end
  end

  // ------------------------------------------------------------------
  // stage 2: drop min and max, keep the middle sum
  // ------------------------------------------------------------------
  tmslf_trim u_trim (
    .smp_i     (s1_smp_q),
    .mid_sum_o (mid_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_free) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_vld_q) begin
      s2_ch_q  <= s1_ch_q;
      s2_sum_q <= mid_sum;
    end
  end

  // ------------------------------------------------------------------
  // stage 3: mean / 3 then / 10 folds into one divide by thirty,
  // done as a reciprocal multiply that is exact over the sum's range
  // ------------------------------------------------------------------
  assign prod = PROD_W'(s2_sum_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (s3_free) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_free && s2_vld_q) begin
      s3_ch_q <= s2_ch_q;
      s3_q_q  <= prod[RECIP_SHIFT +: Q_W];
    end
  end

  // ------------------------------------------------------------------
  // last stage: times ten, slew limit against the stored value
  // ------------------------------------------------------------------
  assign quant  = (SAMPLE_W'(s3_q_q) << 3) + (SAMPLE_W'(s3_q_q) << 1);
  assign ch_ok  = 32'(s3_ch_q) < CHANNELS;
  assign ch_idx = CH_IDX_W'(s3_ch_q);
  // channels beyond the store start from zero and are never written back
  assign prev   = ch_ok ? last_q[ch_idx] : '0;

  tmslf_slew u_slew (
    .cfg_i    (cfg_q),
    .prev_i   (prev),
    .target_i (quant),
    .next_o   (next_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_q[i] <= '0;
      end
    end else if (s3_adv && ch_ok) begin
      last_q[ch_idx] <= next_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_adv) begin
      out_ch_q   <= s3_ch_q;
      out_mean_q <= quant;
      out_filt_q <= next_val;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.out_channel    = out_ch_q;
  assign out_o.quantized_mean = out_mean_q;
  assign out_o.filtered_value = out_filt_q;

endmodule
